// ----- rtl/core/circular_deque_macros.svh -----
// assertion macros for the circular deque
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTH

// property checked on every rising clock edge outside reset
`define CDQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cdq assertion failed");

// implication checked on every rising clock edge outside reset
`define CDQ_ASSERT_IMP(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("cdq implication failed");

// next-cycle implication checked outside reset
`define CDQ_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("cdq next-cycle check failed");

`else

`define CDQ_ASSERT(name, clk, rstn, prop)
`define CDQ_ASSERT_IMP(name, clk, rstn, pre, post)
`define CDQ_ASSERT_NEXT(name, clk, rstn, pre, post)

`endif

`endif

// ----- rtl/core/cdq_pkg.sv -----
// shared types and constants of the circular deque
`default_nettype none

package cdq_pkg;

  // storage geometry
  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed port field widths
  localparam int OP_W     = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;
  localparam int CAP_W    = 8;
  localparam int WIDE_W   = CNT_W + CAP_W;

  // capacity after reset, limited to the store
  localparam int CAP_RST = (128 > DEPTH) ? DEPTH : 128;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/cdq_req_if.sv -----
// request channel: one operation beat
`default_nettype none

interface cdq_req_if;
  logic                        valid;
  logic                        ready;
  logic [cdq_pkg::OP_W-1:0]    op;
  logic [cdq_pkg::WORD_W-1:0]  push_data;

  modport source (output valid, output op, output push_data, input ready);
  modport sink (input valid, input op, input push_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cdq_rsp_if.sv -----
// response channel: one result beat
`default_nettype none

interface cdq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::WORD_W-1:0]    pop_data;
  logic [cdq_pkg::STATUS_W-1:0]  status;
  logic [cdq_pkg::COUNT_W-1:0]   count;
  logic                          is_empty;
  logic                          is_full;

  modport source (output valid, output pop_data, output status, output count,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input pop_data, input status, input count,
                input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cdq_cfg_if.sv -----
// configuration channel: capacity write beat
`default_nettype none

interface cdq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cdq_pkg::CAP_W-1:0]   capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cdq_ctrl.sv -----
// controller state machine of the circular deque
`default_nettype none

module cdq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cdq_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // handshakes and commands
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule

`default_nettype wire

// ----- rtl/core/cdq_dpath.sv -----
// datapath: pointers, free count, slot store and result registers
`default_nettype none

module cdq_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire cdq_pkg::ctrl_cmd_t              cmd_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [cdq_pkg::CAP_W-1:0]       cfg_capacity_i,
  input  wire logic [cdq_pkg::OP_W-1:0]        op_i,
  input  wire logic [cdq_pkg::WORD_W-1:0]      push_data_i,
  output logic [cdq_pkg::WORD_W-1:0]           pop_data_o,
  output logic [cdq_pkg::STATUS_W-1:0]         status_o,
  output logic [cdq_pkg::COUNT_W-1:0]          count_o,
  output logic                                 is_empty_o,
  output logic                                 is_full_o
);

  localparam int IdxW  = cdq_pkg::IDX_W;
  localparam int CntW  = cdq_pkg::CNT_W;
  localparam int DataW = cdq_pkg::DATA_WIDTH;

  // control state
  logic [CntW-1:0]  cap_q, cap_d;
  logic [CntW-1:0]  free_q, free_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  cdq_pkg::status_e status_q, status_d;
  logic             pop_ok_q, pop_ok_d;

  // payload registers
  cdq_pkg::op_e     op_q;
  logic [DataW-1:0] data_q;
  logic [DataW-1:0] rd_q;

  // slot store
  logic [DataW-1:0] mem [cdq_pkg::DEPTH];
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [IdxW-1:0]  mem_raddr;
  logic             mem_re;

  // helpers
  logic [cdq_pkg::WIDE_W-1:0] cap_wide;
  logic [CntW-1:0]  cap_new;
  logic [IdxW-1:0]  cap_last;
  logic [IdxW-1:0]  tail_inc;
  logic [IdxW-1:0]  tail_dec;
  logic [IdxW-1:0]  head_inc;
  logic [IdxW-1:0]  head_dec;
  logic [CntW-1:0]  held;

  // written capacity limited to one..DEPTH
  always_comb begin
    cap_wide = cdq_pkg::WIDE_W'(cfg_capacity_i);
    if (cfg_capacity_i == '0) begin
      cap_new = CntW'(1);
    end else if (cap_wide > cdq_pkg::WIDE_W'(cdq_pkg::DEPTH)) begin
      cap_new = CntW'(cdq_pkg::DEPTH);
    end else begin
      cap_new = CntW'(cap_wide);
    end
  end

  // pointer moves with wraparound at the capacity
  assign cap_last = IdxW'(cap_q - CntW'(1));
  assign tail_inc = (tail_q == cap_last) ? '0 : tail_q + IdxW'(1);
  assign tail_dec = (tail_q == '0) ? cap_last : tail_q - IdxW'(1);
  assign head_inc = (head_q == cap_last) ? '0 : head_q + IdxW'(1);
  assign head_dec = (head_q == '0) ? cap_last : head_q - IdxW'(1);
  assign held     = cap_q - free_q;

  // operation execute
  always_comb begin
    cap_d     = cap_q;
    free_d    = free_q;
    head_d    = head_q;
    tail_d    = tail_q;
    status_d  = status_q;
    pop_ok_d  = pop_ok_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = tail_inc;
    mem_raddr = head_q;
    if (cfg_we_i) begin
      cap_d  = cap_new;
      free_d = cap_new;
      head_d = '0;
      tail_d = IdxW'(cap_new - CntW'(1));
    end else if (cmd_i.exec) begin
      status_d = cdq_pkg::ST_DONE;
      pop_ok_d = 1'b0;
      unique case (op_q)
        cdq_pkg::OP_PUSH_BACK: begin
          if (free_q == '0) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            tail_d    = tail_inc;
            mem_we    = 1'b1;
            mem_waddr = tail_inc;
            free_d    = free_q - CntW'(1);
          end
        end
        cdq_pkg::OP_PUSH_FRONT: begin
          if (free_q == '0) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            head_d    = head_dec;
            mem_we    = 1'b1;
            mem_waddr = head_dec;
            free_d    = free_q - CntW'(1);
          end
        end
        cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
          mem_raddr = (op_q == cdq_pkg::OP_POP_FRONT) ? head_q : tail_q;
          if (held == '0) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            mem_re   = 1'b1;
            pop_ok_d = 1'b1;
            if (op_q == cdq_pkg::OP_POP_FRONT) begin
              head_d = head_inc;
            end else begin
              tail_d = tail_dec;
            end
            free_d = free_q + CntW'(1);
            // last entry gone: pointers back to their reset places
            if (held == CntW'(1)) begin
              head_d = '0;
              tail_d = cap_last;
              free_d = cap_q;
            end
          end
        end
        default: begin
          status_d = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CntW'(cdq_pkg::CAP_RST);
      free_q   <= CntW'(cdq_pkg::CAP_RST);
      head_q   <= '0;
      tail_q   <= IdxW'(cdq_pkg::CAP_RST - 1);
      status_q <= cdq_pkg::ST_DONE;
      pop_ok_q <= 1'b0;
    end else begin
      cap_q    <= cap_d;
      free_q   <= free_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= cdq_pkg::op_e'(op_i);
      data_q <= DataW'(push_data_i);
    end
  end

  // slot store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= data_q;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // result fields
  assign pop_data_o = pop_ok_q ? cdq_pkg::WORD_W'(rd_q) : '0;
  assign status_o   = status_q;
  assign count_o    = cdq_pkg::COUNT_W'(held);
  assign is_empty_o = (held == '0);
  assign is_full_o  = (free_q == '0);

endmodule

`default_nettype wire

// ----- rtl/core/circular_deque.sv -----
// circular double-ended queue over a slot store with a configurable capacity
// a request beat is captured, executed, then its result is held until taken
// one operation at a time, set by the idle/execute/respond sequence around the
// single registered read port: no new request until the last result is taken
// reset: empty deque, capacity 128 limited to the store depth; slots undefined
`default_nettype none
`include "circular_deque_macros.svh"

module circular_deque (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cdq_cfg_if.sink     cfg_if,
  cdq_req_if.sink     req_if,
  cdq_rsp_if.source   rsp_if
);

  cdq_pkg::ctrl_cmd_t cmd;
  logic               in_ready;
  logic               out_valid;

  // configuration is always taken
  assign cfg_if.ready = 1'b1;

  // sequencing
  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_if.ready),
    .cmd_o       (cmd)
  );

  assign req_if.ready = in_ready;
  assign rsp_if.valid = out_valid;

  // storage and arithmetic
  cdq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_if.valid),
    .cfg_capacity_i (cfg_if.capacity),
    .op_i           (req_if.op),
    .push_data_i    (req_if.push_data),
    .pop_data_o     (rsp_if.pop_data),
    .status_o       (rsp_if.status),
    .count_o        (rsp_if.count),
    .is_empty_o     (rsp_if.is_empty),
    .is_full_o      (rsp_if.is_full)
  );

  // checks
  `CDQ_ASSERT(a_one_in_flight, clk_i, rst_ni, !(req_if.ready && rsp_if.valid))
  `CDQ_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, req_if.valid && req_if.ready, !req_if.ready)
  `CDQ_ASSERT_IMP(a_empty_status, clk_i, rst_ni, rsp_if.valid && rsp_if.status == cdq_pkg::ST_EMPTY, rsp_if.is_empty && rsp_if.pop_data == '0)
  `CDQ_ASSERT_IMP(a_flags_exclusive, clk_i, rst_ni, rsp_if.valid, !(rsp_if.is_empty && rsp_if.is_full))

endmodule

`default_nettype wire

// ----- test/circular_deque_test.sv -----
// self-checking testbench of the circular deque: directed and random operation beats
`default_nettype none

module circular_deque_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int unsigned STIM_OPS    = 1950;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef enum logic [1:0] {
    BEAT_OP,
    BEAT_CFG,
    BEAT_DRAIN
  } beat_kind_e;

  typedef struct {
    beat_kind_e        kind;
    op_e               op;
    logic [WORD_W-1:0] word;
    logic [CAP_W-1:0]  cap;
    int unsigned       gap;
  } stim_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0]  pop_data;
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } deque_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cdq_cfg_if cfg_bus ();
  cdq_req_if req_bus ();
  cdq_rsp_if rsp_bus ();

  circular_deque uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_bus),
    .req_if (req_bus),
    .rsp_if (rsp_bus)
  );

  // stimulus and scoreboard state
  stim_beat_t  pending_q[$];
  deque_rsp_t  expected_q[$];
  int unsigned in_flight = 0;
  int unsigned fail_count = 0;
  bit          stim_done = 1'b0;
  bit          calm_phase = 1'b0;

  // shadow of the deque
  logic [WORD_W-1:0] shadow_slots [DEPTH];
  int unsigned       shadow_head;
  int unsigned       shadow_tail;
  int unsigned       shadow_free;
  int unsigned       shadow_cap;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reset and idle levels on every input
  initial begin
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.op          = OP_PUSH_BACK;
    req_bus.push_data   = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.capacity    = CAP_W'(CAP_RST);
    rsp_bus.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // head and tail back to their initial slots
  function automatic void shadow_clear();
    shadow_head = 0;
    shadow_tail = shadow_cap - 1;
    shadow_free = shadow_cap;
  endfunction

  // capacity write, limited to 1..DEPTH
  function automatic void shadow_set_cap(logic [CAP_W-1:0] value);
    if (value == 0)
      shadow_cap = 1;
    else if (int'(value) > DEPTH)
      shadow_cap = DEPTH;
    else
      shadow_cap = value;
    shadow_clear();
  endfunction

  // one operation on the shadow deque and the result it gives
  function automatic deque_rsp_t deque_apply(op_e op, logic [WORD_W-1:0] word);
    deque_rsp_t  rsp;
    int unsigned held;
    rsp = '{pop_data: '0, status: ST_DONE, count: '0, is_empty: 1'b0, is_full: 1'b0};
    if (shadow_free > shadow_cap)
      shadow_free = shadow_cap;
    held = shadow_cap - shadow_free;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_free == 0) begin
          rsp.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          shadow_tail = (shadow_tail + 1) % shadow_cap;
          shadow_slots[shadow_tail] = word;
          shadow_free--;
        end else begin
          shadow_head = (shadow_head + shadow_cap - 1) % shadow_cap;
          shadow_slots[shadow_head] = word;
          shadow_free--;
        end
      end
      default: begin
        if (held == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) begin
            rsp.pop_data = shadow_slots[shadow_head];
            shadow_head = (shadow_head + 1) % shadow_cap;
          end else begin
            rsp.pop_data = shadow_slots[shadow_tail];
            shadow_tail = (shadow_tail + shadow_cap - 1) % shadow_cap;
          end
          shadow_free++;
          if (shadow_free >= shadow_cap)
            shadow_clear();
        end
      end
    endcase
    held         = shadow_cap - shadow_free;
    rsp.count    = COUNT_W'(held);
    rsp.is_empty = (held == 0);
    rsp.is_full  = (shadow_free == 0);
    return rsp;
  endfunction

  // sender gap: none in a calm phase, else mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_phase)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic void add_op(op_e op, logic [WORD_W-1:0] word);
    pending_q.push_back('{kind: BEAT_OP, op: op, word: word, cap: '0, gap: pick_gap()});
  endfunction

  function automatic void add_cfg(logic [CAP_W-1:0] cap);
    pending_q.push_back('{kind: BEAT_CFG, op: OP_PUSH_BACK, word: '0, cap: cap,
                          gap: pick_gap()});
  endfunction

  function automatic void add_drain();
    pending_q.push_back('{kind: BEAT_DRAIN, op: OP_PUSH_BACK, word: '0, cap: '0, gap: 0});
  endfunction

  // random word, with the all-zero and all-one extremes now and then
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return $urandom;
  endfunction

  // stimulus
  initial begin
    int unsigned op_total;
    int unsigned phase_len;
    int unsigned push_bias;
    int unsigned r;
    int unsigned n;
    bit          drained;

    // empty pops, push front into an empty deque, wraparound at full capacity
    add_op(OP_POP_FRONT, '1);
    add_op(OP_POP_BACK, '0);
    add_op(OP_PUSH_FRONT, '1);
    add_op(OP_PUSH_BACK, '0);
    add_op(OP_PUSH_FRONT, 32'hA5A5_A5A5);
    add_op(OP_POP_BACK, '1);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_FRONT, 32'h5A5A_5A5A);
    add_op(OP_POP_BACK, '1);
    // single slot: full and empty on the same entry
    add_cfg(8'd1);
    add_op(OP_PUSH_BACK, 32'h1234_5678);
    add_op(OP_PUSH_FRONT, 32'h5A5A_5A5A);
    add_op(OP_PUSH_BACK, '1);
    add_op(OP_POP_BACK, '0);
    add_op(OP_PUSH_FRONT, '1);
    add_op(OP_POP_FRONT, '0);
    // zero capacity behaves as one slot
    add_cfg(8'd0);
    add_op(OP_PUSH_FRONT, 32'h8000_0001);
    add_op(OP_PUSH_BACK, 32'h7FFF_FFFE);
    add_op(OP_POP_FRONT, '0);
    // capacity beyond the store is limited to its depth
    add_cfg(8'hFF);
    add_op(OP_PUSH_BACK, 32'h7FFF_FFFE);
    add_op(OP_POP_FRONT, '1);
    // two slots, filled from the front
    add_cfg(8'd2);
    add_op(OP_PUSH_FRONT, 32'h0000_0001);
    add_op(OP_PUSH_FRONT, 32'h0000_0002);
    add_op(OP_PUSH_FRONT, 32'h0000_0003);
    add_op(OP_POP_BACK, '0);
    add_op(OP_POP_BACK, '0);

    // whole store filled past full, then emptied from both ends
    add_cfg(8'd128);
    for (int i = 0; i < 132; i++)
      add_op(($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    add_drain();
    for (int i = 0; i < 132; i++)
      add_op(($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK, '0);
    op_total = 264;

    // random phases, each under its own push bias, most under a new capacity
    drained = 1'b0;
    while (op_total < STIM_OPS) begin
      calm_phase = ($urandom_range(0, 4) == 0);
      if (op_total == 264 || $urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        if (r < 4)
          add_cfg(CAP_W'($urandom_range(1, 8)));
        else if (r < 6)
          add_cfg(CAP_W'($urandom_range(9, 127)));
        else if (r == 6)
          add_cfg(8'd128);
        else if (r == 7)
          add_cfg(CAP_W'($urandom_range(129, 255)));
        else if (r == 8)
          add_cfg(8'd0);
        else
          add_cfg(8'd1);
      end
      r = $urandom_range(0, 3);
      push_bias = (r == 0) ? 25 : (r == 1) ? 50 : (r == 2) ? 75 : 90;
      phase_len = $urandom_range(40, 160);
      for (n = 0; n < phase_len; n++) begin
        if (n == phase_len / 2 && (!drained || $urandom_range(0, 3) == 0)) begin
          add_drain();
          drained = 1'b1;
        end
        if ($urandom_range(0, 99) < push_bias)
          add_op(($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
        else
          add_op(($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
      end
      op_total += phase_len;
    end
  end

  // driver: one beat at a time from the pending queue
  always @(posedge clk_i) begin
    logic nxt_req;
    logic nxt_cfg;
    bit   idle_now;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else if (!((req_bus.valid && !req_bus.ready) || (cfg_bus.valid && !cfg_bus.ready))) begin
      nxt_req  = 1'b0;
      nxt_cfg  = 1'b0;
      idle_now = !req_bus.valid && !cfg_bus.valid && (in_flight == 0);
      if (pending_q.size() == 0) begin
        stim_done = 1'b1;
      end else if (pending_q[0].gap != 0) begin
        pending_q[0].gap = pending_q[0].gap - 1;
      end else begin
        case (pending_q[0].kind)
          BEAT_OP: begin
            nxt_req            = 1'b1;
            req_bus.op        <= pending_q[0].op;
            req_bus.push_data <= pending_q[0].word;
            void'(pending_q.pop_front());
          end
          BEAT_CFG: begin
            // capacity only changes with nothing in flight
            if (idle_now) begin
              nxt_cfg           = 1'b1;
              cfg_bus.capacity <= pending_q[0].cap;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            // hold off until every result is back
            if (idle_now)
              void'(pending_q.pop_front());
          end
        endcase
      end
      req_bus.valid <= nxt_req;
      cfg_bus.valid <= nxt_cfg;
    end
  end

  // monitor: shadow update on capacity beats, prediction on request beats, checking on result beats
  always @(posedge clk_i) begin
    deque_rsp_t  want;
    bit          req_beat;
    bit          rsp_beat;
    int unsigned r;
    static int unsigned stall_left = 0;
    static int unsigned calm_left = 0;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      in_flight     <= 0;
      shadow_cap     = CAP_RST;
      shadow_clear();
    end else begin
      req_beat = req_bus.valid && req_bus.ready;
      rsp_beat = rsp_bus.valid && rsp_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready)
        shadow_set_cap(cfg_bus.capacity);
      if (req_beat)
        expected_q.push_back(deque_apply(op_e'(req_bus.op), req_bus.push_data));
      if (rsp_beat) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_bus.pop_data !== want.pop_data) begin
            $error("pop_data: expected %h, actual %h", want.pop_data, rsp_bus.pop_data);
            fail_count++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_bus.count);
            fail_count++;
          end
          if (rsp_bus.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, actual %0b", want.is_empty, rsp_bus.is_empty);
            fail_count++;
          end
          if (rsp_bus.is_full !== want.is_full) begin
            $error("is_full: expected %0b, actual %0b", want.is_full, rsp_bus.is_full);
            fail_count++;
          end
        end
      end
      in_flight <= in_flight + req_beat - rsp_beat;

      // receiver stalls, with calm stretches in between
      if (stall_left != 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        rsp_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          calm_left = $urandom_range(50, 300);
          rsp_bus.ready <= 1'b1;
        end else if (r < 60) begin
          rsp_bus.ready <= 1'b1;
        end else if (r < 92) begin
          stall_left = $urandom_range(0, 2);
          rsp_bus.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(8, 30);
          rsp_bus.ready <= 1'b0;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk_i);
    wait (in_flight == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("circular_deque_test: PASS");
    end else begin
      if (expected_q.size() != 0)
        $error("%0d results never arrived", expected_q.size());
      $display("circular_deque_test: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $error("run did not finish in time");
    $display("circular_deque_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- circular_deque.f -----
+incdir+rtl/core
rtl/core/cdq_pkg.sv
rtl/core/cdq_req_if.sv
rtl/core/cdq_rsp_if.sv
rtl/core/cdq_cfg_if.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_dpath.sv
rtl/core/circular_deque.sv
test/circular_deque_test.sv
